@@ rtl/tow_pkg.sv @@
// ---------------------------------------------------------------------------
// tow_pkg: shared types and constants of the TCP option walker
// Beat structs, parse phases, result status codes and queue sizing.
// ---------------------------------------------------------------------------
package tow_pkg;

  // default and widest supported option area
  localparam int unsigned MaxAreaBytes = 40;

  // depth of the record queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // parse phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_KIND = 2'd1,
    PH_LEN  = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_END       = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_e;

  // input beat
  typedef struct packed {
    logic       start_req;
    logic [5:0] area_length;
    logic [7:0] opt_byte;
  } tow_in_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] kind;
    logic [7:0] opt_length;
    logic [5:0] data_offset;
    logic       finished;
  } tow_out_t;

  // one queued record: a result, optionally followed by an exhausted result
  typedef struct packed {
    tow_out_t first;
    logic     tail_exh;
  } tow_rec_t;

  // the exhausted result that ends an area without an end marker
  function automatic tow_out_t exhausted_res();
    tow_out_t r;
    r.status      = ST_EXHAUSTED;
    r.kind        = 8'd0;
    r.opt_length  = 8'd0;
    r.data_offset = 6'd0;
    r.finished    = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/tow_front.sv @@
// ---------------------------------------------------------------------------
// tow_front: option area parser
// Takes one area byte per beat, updates the parse state and produces a
// record of the results that byte causes.
// ---------------------------------------------------------------------------
module tow_front #(
  parameter int unsigned MAX_AREA_BYTES = tow_pkg::MaxAreaBytes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  tow_pkg::tow_in_t item_i,
  output logic             rec_valid_o,
  output tow_pkg::tow_rec_t rec_o
);

  tow_pkg::phase_e phase_q, phase_d;
  logic [5:0]      rem_q, rem_d;
  logic [7:0]      skip_q, skip_d;
  logic [5:0]      pos_q, pos_d;
  logic [7:0]      kind_q, kind_d;

  logic [5:0]      alen_sat;
  logic [7:0]      b;
  logic [5:0]      off_next;

  assign b        = item_i.opt_byte;
  assign alen_sat = (item_i.area_length > 6'(MAX_AREA_BYTES)) ?
                    6'(MAX_AREA_BYTES) : item_i.area_length;
  // offset after the length byte, taken from the registered position
  assign off_next = pos_q + 6'd1;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tow_pkg::PH_IDLE;
      rem_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      kind_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    skip_d      = skip_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;

    // new area
    if (item_i.start_req) begin
      rem_d   = alen_sat;
      pos_d   = '0;
      skip_d  = '0;
      kind_d  = '0;
      phase_d = tow_pkg::PH_KIND;
    end

    if (item_i.start_req && (alen_sat == 6'd0)) begin
      // empty area ends at once
      rec_valid_o = 1'b1;
      rec_o.first = tow_pkg::exhausted_res();
      phase_d     = tow_pkg::PH_IDLE;
    end else begin
      case (phase_d)
        tow_pkg::PH_KIND: begin
          if (b == 8'd0) begin
            // end of list marker
            rec_valid_o       = 1'b1;
            rec_o.first.status   = tow_pkg::ST_END;
            rec_o.first.finished = 1'b1;
            phase_d = tow_pkg::PH_IDLE;
            rem_d   = rem_d - 6'd1;
            pos_d   = pos_d + 6'd1;
          end else if (b == 8'd1) begin
            // single byte pad
            rec_valid_o            = 1'b1;
            rec_o.first.status     = tow_pkg::ST_FOUND;
            rec_o.first.kind       = 8'd1;
            rec_o.first.opt_length = 8'd1;
            rem_d = rem_d - 6'd1;
            pos_d = pos_d + 6'd1;
            if (rem_d == 6'd0) begin
              rec_o.tail_exh = 1'b1;
              phase_d        = tow_pkg::PH_IDLE;
            end
          end else begin
            kind_d = b;
            rem_d  = rem_d - 6'd1;
            pos_d  = pos_d + 6'd1;
            if (rem_d == 6'd0) begin
              // no room left for the length byte
              rec_valid_o          = 1'b1;
              rec_o.first.status   = tow_pkg::ST_OVERRUN;
              rec_o.first.kind     = b;
              rec_o.first.finished = 1'b1;
              phase_d = tow_pkg::PH_IDLE;
            end else begin
              phase_d = tow_pkg::PH_LEN;
            end
          end
        end
        tow_pkg::PH_LEN: begin
          rec_valid_o            = 1'b1;
          rec_o.first.kind       = kind_d;
          rec_o.first.opt_length = b;
          if (b < 8'd2) begin
            rec_o.first.status   = tow_pkg::ST_SHORT;
            rec_o.first.finished = 1'b1;
            phase_d = tow_pkg::PH_IDLE;
          end else if ({1'b0, b} > (9'(rem_d) + 9'd1)) begin
            rec_o.first.status      = tow_pkg::ST_OVERRUN;
            rec_o.first.data_offset = off_next;
            rec_o.first.finished    = 1'b1;
            phase_d = tow_pkg::PH_IDLE;
          end else begin
            rec_o.first.status      = tow_pkg::ST_FOUND;
            rec_o.first.data_offset = off_next;
            skip_d  = b - 8'd2;
            phase_d = (skip_d != 8'd0) ? tow_pkg::PH_SKIP : tow_pkg::PH_KIND;
          end
          rem_d = rem_d - 6'd1;
          pos_d = off_next;
          if ((phase_d != tow_pkg::PH_IDLE) && (rem_d == 6'd0)) begin
            rec_o.tail_exh = 1'b1;
            phase_d        = tow_pkg::PH_IDLE;
          end
        end
        tow_pkg::PH_SKIP: begin
          rem_d  = rem_d - 6'd1;
          pos_d  = pos_d + 6'd1;
          skip_d = skip_d - 8'd1;
          if (skip_d == 8'd0) begin
            phase_d = tow_pkg::PH_KIND;
          end
          if (rem_d == 6'd0) begin
            rec_valid_o = 1'b1;
            rec_o.first = tow_pkg::exhausted_res();
            phase_d     = tow_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle: byte ignored
        end
      endcase
    end

    // nothing leaves without an accepted beat
    if (!accept_i) begin
      rec_valid_o = 1'b0;
    end
  end

endmodule

@@ rtl/tow_queue.sv @@
// ---------------------------------------------------------------------------
// tow_queue: record queue between parser and result stage
// Small register queue; head record is visible while not empty.
// ---------------------------------------------------------------------------
module tow_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tow_pkg::tow_rec_t rec_i,
  input  logic              pop_i,
  output tow_pkg::tow_rec_t head_o,
  output logic              full_o,
  output logic              empty_o
);

  tow_pkg::tow_rec_t              mem_q [tow_pkg::QDepth];
  logic [tow_pkg::QPtrW-1:0]      wptr_q, rptr_q;
  logic [tow_pkg::QCntW-1:0]      cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == tow_pkg::QCntW'(tow_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == tow_pkg::QPtrW'(tow_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == tow_pkg::QPtrW'(tow_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tow_back.sv @@
// ---------------------------------------------------------------------------
// tow_back: result stage
// Expands each queued record into one or two result beats.
// ---------------------------------------------------------------------------
module tow_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tow_pkg::tow_rec_t head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  logic              pop,
  output logic              empty,
  output tow_pkg::tow_out_t result_o,
  output logic              second_o
);

  logic sec_q, sec_d;
  logic take;

  assign empty    = q_empty_i;
  assign take     = pop && !q_empty_i;
  assign result_o = sec_q ? tow_pkg::exhausted_res() : head_i.first;
  assign second_o = sec_q;

  // move to the trailing exhausted beat or retire the record
  always_comb begin
    sec_d   = sec_q;
    q_pop_o = 1'b0;
    if (take) begin
      if (head_i.tail_exh && !sec_q) begin
        sec_d = 1'b1;
      end else begin
        sec_d   = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= 1'b0;
    end else begin
      sec_q <= sec_d;
    end
  end

endmodule

@@ rtl/tcp_option_walker_unit.sv @@
// ---------------------------------------------------------------------------
// tcp_option_walker_unit: TCP option area walker
// Parses an option area one byte per beat and reports options, pads,
// end marker and malformed cases as result beats.
// ---------------------------------------------------------------------------
//  channel   handshake         payload                    direction
//  input     push / full       item_i   (tow_in_t)        in
//  result    pop / empty       result_o (tow_out_t)       out
//
//  One input beat is taken per cycle while full is low; its parse step is done
//  in that cycle and its record enters a 4-entry queue.
//  A byte yields zero, one or two result beats; results drain at one per
//  cycle while pop is high, so a byte with two results needs two pops.
//  full rises only when the queue holds 4 undrained records.
//  Reset clears the parse state and the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module tcp_option_walker_unit #(
  parameter int unsigned MAX_AREA_BYTES = tow_pkg::MaxAreaBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tow_pkg::tow_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output tow_pkg::tow_out_t result_o
);

  logic              accept;
  logic              rec_valid;
  tow_pkg::tow_rec_t rec, head;
  logic              q_empty, q_pop, second;

  assign accept = push && !full;

  // parser
  tow_front #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .rec_valid_o(rec_valid),
    .rec_o      (rec)
  );

  // record queue
  tow_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_valid),
    .rec_i  (rec),
    .pop_i  (q_pop),
    .head_o (head),
    .full_o (full),
    .empty_o(q_empty)
  );

  // result stage
  tow_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result_o (result_o),
    .second_o (second)
  );

  // checks
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue full while empty");

  a_second_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second |-> (!empty && head.tail_exh))
    else $error("trailing beat without a record");

  a_second_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second |-> (result_o.finished &&
                (result_o.status == tow_pkg::ST_EXHAUSTED)))
    else $error("trailing beat is not a final exhausted result");

  a_second_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (second && pop) |=> !second)
    else $error("trailing beat not retired");

endmodule

@@ bench/tow_check_pkg.sv @@
// ---------------------------------------------------------------------------
// tow_check_pkg: result predictor and scoreboard for the option walker
// Tracks the parse state of the walker beat by beat, queues the results each
// accepted input beat should cause, and compares result beats field by field.
// ---------------------------------------------------------------------------
package tow_check_pkg;

  import tow_pkg::*;

  class tow_result_checker;

    // mirrored parse state
    phase_e      phase;
    logic [8:0]  remaining;
    logic [7:0]  skip_count;
    logic [5:0]  position;
    logic [7:0]  cur_kind;

    // results still owed by the walker, oldest first
    tow_out_t    expected_q[$];

    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen[5];

    function new();
      phase      = PH_IDLE;
      remaining  = '0;
      skip_count = '0;
      position   = '0;
      cur_kind   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void post(status_e st, logic [7:0] kd, logic [7:0] ln, logic [5:0] off,
                       logic fin);
      tow_out_t r;
      r.status      = st;
      r.kind        = kd;
      r.opt_length  = ln;
      r.data_offset = off;
      r.finished    = fin;
      expected_q.push_back(r);
    endfunction

    function void advance();
      remaining = remaining - 9'd1;
      position  = position + 6'd1;
    endfunction

    // area used up without an end marker
    function void close_if_exhausted();
      if (phase != PH_IDLE && remaining == '0) begin
        post(ST_EXHAUSTED, 8'd0, 8'd0, 6'd0, 1'b1);
        phase = PH_IDLE;
      end
    endfunction

    // one accepted input beat; returns 0 when the walker just ignores it
    function bit note_beat(tow_in_t beat);
      logic [7:0] b;
      b = beat.opt_byte;
      if (!beat.start_req && phase == PH_IDLE) return 1'b0;

      // new area, oversize lengths clamp to the maximum
      if (beat.start_req) begin
        if (beat.area_length > MaxAreaBytes) remaining = 9'(MaxAreaBytes);
        else remaining = 9'(beat.area_length);
        position   = '0;
        skip_count = '0;
        cur_kind   = '0;
        phase      = PH_KIND;
        if (remaining == '0) begin
          post(ST_EXHAUSTED, 8'd0, 8'd0, 6'd0, 1'b1);
          phase = PH_IDLE;
          return 1'b1;
        end
      end

      case (phase)
        PH_KIND: begin
          if (b == 8'd0) begin
            post(ST_END, 8'd0, 8'd0, 6'd0, 1'b1);
            phase = PH_IDLE;
            advance();
          end else if (b == 8'd1) begin
            post(ST_FOUND, 8'd1, 8'd1, 6'd0, 1'b0);
            advance();
            close_if_exhausted();
          end else begin
            cur_kind = b;
            advance();
            // no room left for the length byte
            if (remaining == '0) begin
              post(ST_OVERRUN, cur_kind, 8'd0, 6'd0, 1'b1);
              phase = PH_IDLE;
            end else begin
              phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (b < 8'd2) begin
            post(ST_SHORT, cur_kind, b, 6'd0, 1'b1);
            phase = PH_IDLE;
            advance();
          end else if ({1'b0, b} > remaining + 9'd1) begin
            post(ST_OVERRUN, cur_kind, b, position + 6'd1, 1'b1);
            phase = PH_IDLE;
            advance();
          end else begin
            post(ST_FOUND, cur_kind, b, position + 6'd1, 1'b0);
            advance();
            skip_count = b - 8'd2;
            phase = (skip_count != '0) ? PH_SKIP : PH_KIND;
            close_if_exhausted();
          end
        end
        PH_SKIP: begin
          advance();
          skip_count = skip_count - 8'd1;
          if (skip_count == '0) phase = PH_KIND;
          close_if_exhausted();
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    // one accepted result beat against the oldest expectation
    function void check_result(tow_out_t got);
      tow_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: status %0d kind %0d length %0d",
               got.status, got.kind, got.opt_length);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.status < 5) status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.opt_length !== want.opt_length) begin
        $error("opt_length: expected %0d, got %0d", want.opt_length, got.opt_length);
        mismatches++;
      end
      if (got.data_offset !== want.data_offset) begin
        $error("data_offset: expected %0d, got %0d", want.data_offset, got.data_offset);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, got %0d", want.finished, got.finished);
        mismatches++;
      end
    endfunction

  endclass

endpackage

@@ bench/tcp_option_walker_unit_tb.sv @@
// ---------------------------------------------------------------------------
// tcp_option_walker_unit_tb: testbench of the TCP option walker
// Feeds directed corner-case areas, then mostly well-formed random option
// areas mixed with noise, under varying idle rates on both queue sides and
// a long result stall; every result beat is checked against the predictor.
// ---------------------------------------------------------------------------
module tcp_option_walker_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tow_pkg::*;
  import tow_check_pkg::*;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned PhaseBeats = 700;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  tow_in_t     item;
  tow_out_t    result;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          rx_hold_req;
  bit          rx_hold;
  int unsigned walked_beats;

  tow_result_checker result_chk = new();

  tcp_option_walker_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side, random stalls or a forced hold-off
  always @(posedge clk_i) begin
    if (rx_hold) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) result_chk.check_result(result);
  end

  // long receiver hold-off, counted here once requested
  initial begin
    rx_hold = 1'b0;
    wait (rx_hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic start, input logic [5:0] alen, input logic [7:0] b);
    tow_in_t beat;
    beat.start_req   = start;
    beat.area_length = alen;
    beat.opt_byte    = b;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item <= beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (result_chk.note_beat(beat)) walked_beats++;
  endtask

  // stop sending until every owed result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (result_chk.pending() != 0) @(posedge clk_i);
  endtask

  // one random area: mostly well-formed options, sometimes plain noise
  task automatic send_random_area();
    logic [7:0] bytes[$];
    int         eff;
    int         left;
    int         len;
    int         p;
    logic [5:0] alen;
    bit         noise;
    logic       start;
    p = $urandom_range(0, 99);
    if (p < 5) alen = 6'd0;
    else if (p < 10) alen = 6'($urandom_range(41, 63));
    else if (p < 60) alen = 6'($urandom_range(1, 12));
    else alen = 6'($urandom_range(1, 40));
    eff   = (alen > MaxAreaBytes) ? MaxAreaBytes : alen;
    noise = ($urandom_range(0, 99) < 15);

    if (noise) begin
      repeat ($urandom_range(1, eff + 3)) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (bytes.size() < eff) begin
        left = eff - bytes.size();
        p = $urandom_range(0, 99);
        if (p < 6) begin
          bytes.push_back(8'd0);
          break;
        end else if (p < 24) begin
          bytes.push_back(8'd1);
        end else begin
          bytes.push_back(8'($urandom_range(2, 255)));
          if (left > 1) begin
            if (left > 12 && $urandom_range(0, 3) != 0) len = $urandom_range(2, 12);
            else len = $urandom_range(2, left);
            // occasional broken length byte
            if ($urandom_range(0, 99) < 4) len = $urandom_range(0, 255);
            bytes.push_back(8'(len));
            for (int i = 2; i < len && bytes.size() < eff; i++)
              bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      if (bytes.size() == 0) bytes.push_back(8'($urandom_range(0, 255)));
    end

    foreach (bytes[i]) begin
      start = (i == 0) || (noise && $urandom_range(0, 99) < 5);
      send_beat(start, (i == 0) ? alen : 6'($urandom_range(0, 63)), bytes[i]);
    end
    // stray bytes after the parse ends
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_beat(1'b0, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    item          = '0;
    rx_hold_req   = 1'b0;
    walked_beats  = 0;
    src_idle_pct  = 16;
    sink_idle_pct = 47;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte while idle, empty area
    send_beat(1'b0, 6'h3F, 8'hFF);
    send_beat(1'b1, 6'd0, 8'hAA);
    // pad as the last byte: pad then exhausted in one step
    send_beat(1'b1, 6'd1, 8'd1);
    // length byte as the last byte: option then exhausted
    send_beat(1'b1, 6'd2, 8'd3);
    send_beat(1'b0, 6'd0, 8'd2);
    // pad, option with data, area runs out on the data
    send_beat(1'b1, 6'd5, 8'd1);
    send_beat(1'b0, 6'd0, 8'd2);
    send_beat(1'b0, 6'd0, 8'd4);
    send_beat(1'b0, 6'd0, 8'hAB);
    send_beat(1'b0, 6'd0, 8'h55);
    // end marker
    send_beat(1'b1, 6'd3, 8'd0);
    // kind in the last position, no room for its length
    send_beat(1'b1, 6'd1, 8'd8);
    // lengths below two
    send_beat(1'b1, 6'd4, 8'd5);
    send_beat(1'b0, 6'd0, 8'd1);
    send_beat(1'b1, 6'd4, 8'd5);
    send_beat(1'b0, 6'd0, 8'd0);
    // option longer than the area
    send_beat(1'b1, 6'd4, 8'd254);
    send_beat(1'b0, 6'd0, 8'd255);
    // start while busy, oversize area clamps
    send_beat(1'b1, 6'd3, 8'd7);
    send_beat(1'b1, 6'h3F, 8'd2);
    send_beat(1'b0, 6'd0, 8'd40);
    send_beat(1'b0, 6'd0, 8'h80);
    send_beat(1'b1, 6'd40, 8'd0);
    wait_drained();

    // random, sender idles less than the receiver; long result stall early on
    rx_hold_req = 1'b1;
    while (walked_beats < PhaseBeats) send_random_area();
    wait_drained();

    // random, receiver idles less than the sender
    src_idle_pct  = 47;
    sink_idle_pct = 16;
    while (walked_beats < 2 * PhaseBeats) send_random_area();
    wait_drained();

    // random, no idling at all
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (walked_beats < 3 * PhaseBeats) send_random_area();
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("walked %0d option bytes, checked %0d results", walked_beats,
             result_chk.checked);
    $display("found %0d, end %0d, exhausted %0d, short %0d, overrun %0d",
             result_chk.status_seen[ST_FOUND], result_chk.status_seen[ST_END],
             result_chk.status_seen[ST_EXHAUSTED], result_chk.status_seen[ST_SHORT],
             result_chk.status_seen[ST_OVERRUN]);
    if (result_chk.mismatches == 0 && result_chk.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
